>>> hw/rtl/rgb_to_hsv_converter_assert.svh
// assertion macros for the rgb to hsv converter checker
// expects clk and arst_n in the scope where a macro is used
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define RHC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/rhc_pkg.sv
// shared types and constants for the rgb to hsv converter
// no dependencies
`default_nettype none

package rhc_pkg;

	localparam int CHAN_W     = 8;
	localparam int HUE_W      = 9;
	// quotient bits per divide, one pipeline stage each
	localparam int QUOT_W     = 8;
	localparam int NUM_W      = CHAN_W + QUOT_W;

	localparam int FULL_SCALE = 255;
	localparam int SECTOR_DEG = 60;
	localparam int CIRCLE_DEG = 360;

	localparam logic [HUE_W-1:0] HUE_RED_WRAP = HUE_W'(CIRCLE_DEG);
	localparam logic [HUE_W-1:0] HUE_GREEN    = HUE_W'(2 * SECTOR_DEG);
	localparam logic [HUE_W-1:0] HUE_BLUE     = HUE_W'(4 * SECTOR_DEG);

	// channel holding the maximum, ties resolved red, green, blue
	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// per-pixel control carried alongside the dividers
	typedef struct packed {
		sector_t             sector;
		logic                neg;
		logic                grey;
		logic                black;
		logic [CHAN_W-1:0]   brightness;
	} side_t;

endpackage

`default_nettype wire

>>> hw/rtl/rhc_front.sv
// first stage: max, min, delta, sector and divide numerators
// depends on rhc_pkg
`default_nettype none

module rhc_front import rhc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              pix_valid,
	input  wire logic [CHAN_W-1:0] red,
	input  wire logic [CHAN_W-1:0] green,
	input  wire logic [CHAN_W-1:0] blue,
	output logic                   valid_s1,
	output side_t                  side_s1,
	output logic [NUM_W-1:0]       sat_num_s1,
	output logic [NUM_W-1:0]       hue_num_s1,
	output logic [CHAN_W-1:0]      delta_s1
);

	sector_t           sector;
	logic [CHAN_W-1:0] max_val;
	logic [CHAN_W-1:0] min_val;
	logic [CHAN_W-1:0] delta;
	logic [CHAN_W-1:0] opa;
	logic [CHAN_W-1:0] opb;
	logic              neg;
	logic [CHAN_W-1:0] mag;
	side_t             side;

	always_comb begin
		if (red >= green && red >= blue) begin
			sector  = SEC_RED;
			max_val = red;
			opa     = green;
			opb     = blue;
		end else if (green >= blue) begin
			sector  = SEC_GREEN;
			max_val = green;
			opa     = blue;
			opb     = red;
		end else begin
			sector  = SEC_BLUE;
			max_val = blue;
			opa     = red;
			opb     = green;
		end

		if (red <= green && red <= blue) begin
			min_val = red;
		end else if (green <= blue) begin
			min_val = green;
		end else begin
			min_val = blue;
		end

		delta = max_val - min_val;
		neg   = (opa < opb);
		mag   = neg ? (opb - opa) : (opa - opb);

		side.sector     = sector;
		side.neg        = neg;
		side.grey       = (delta == '0);
		side.black      = (max_val == '0);
		side.brightness = max_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pix_valid;
		end
	end

	// delta*255 and 60*|diff| as shift and subtract
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1    <= side;
			delta_s1   <= delta;
			sat_num_s1 <= (NUM_W'(delta) << CHAN_W) - NUM_W'(delta);
			hue_num_s1 <= (NUM_W'(mag) << 6) - (NUM_W'(mag) << 2);
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/rhc_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
// numerator must be below den << QW; depends on nothing but its parameters
`default_nettype none

module rhc_div_pipe #(
	parameter int DW = 8,
	parameter int QW = 8
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [DW+QW-1:0] numer,
	input  wire logic [DW-1:0]    den,
	output logic [QW-1:0]         quot,
	output logic [DW-1:0]         rem
);

	// index k is after k stages
	logic [DW-1:0] rem_s [1:QW];
	logic [DW-1:0] den_s [1:QW];
	logic [QW-1:0] lo_s  [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] lo_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = numer[DW+QW-1:QW];
			assign lo_in  = numer[QW-1:0];
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign lo_in  = lo_s[k];
			assign den_in = den_s[k];
		end

		always_comb begin
			trial = {rem_in, lo_in[QW-1]};
			diff  = trial - {1'b0, den_in};
			ge    = (trial >= {1'b0, den_in});
		end

		// low bits shift out as quotient bits shift in
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				lo_s[k+1]  <= {lo_in[QW-2:0], ge};
				den_s[k+1] <= den_in;
			end
		end
	end

	assign quot = lo_s[QW];
	assign rem  = rem_s[QW];

endmodule

`default_nettype wire

>>> hw/rtl/rhc_post.sv
// last stage: floor correction, sector offset, grey and black cases
// depends on rhc_pkg
`default_nettype none

module rhc_post import rhc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_in,
	input  wire side_t             side,
	input  wire logic [QUOT_W-1:0] hue_quot,
	input  wire logic [CHAN_W-1:0] hue_rem,
	input  wire logic [QUOT_W-1:0] sat_quot,
	output logic                   hsv_valid,
	output logic [HUE_W-1:0]       hue_degrees,
	output logic [CHAN_W-1:0]      saturation,
	output logic [CHAN_W-1:0]      brightness
);

	logic [HUE_W-1:0] mag;
	logic [HUE_W-1:0] hue;

	always_comb begin
		// negative quotients round toward minus infinity
		mag = side.neg ? (HUE_W'(hue_quot) + HUE_W'(hue_rem != '0)) : HUE_W'(hue_quot);
		case (side.sector)
			SEC_RED:   hue = side.neg ? (HUE_RED_WRAP - mag) : mag;
			SEC_GREEN: hue = side.neg ? (HUE_GREEN - mag) : (HUE_GREEN + mag);
			SEC_BLUE:  hue = side.neg ? (HUE_BLUE - mag) : (HUE_BLUE + mag);
			default:   hue = '0;
		endcase
		if (side.grey) begin
			hue = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid <= 1'b0;
		end else if (en) begin
			hsv_valid <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_degrees <= hue;
			saturation  <= side.black ? '0 : sat_quot[CHAN_W-1:0];
			brightness  <= side.brightness;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/rgb_to_hsv_converter.sv
// rgb to hsv converter, top level
// depends on rhc_pkg, rhc_front, rhc_div_pipe, rhc_post
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  pixel   | pix_valid, pix_stall | red, green, blue (8b each)
//  hsv     | hsv_valid, hsv_stall | hue_degrees (9b), saturation, brightness
//
// one pixel per clock when not stalled: one front stage, eight divider
// stages (one quotient bit each for the saturation and hue divides), one
// output stage. reset clears only the valid bits. when a result is held
// by hsv_stall the whole pipe freezes and pix_stall is raised; nothing is
// dropped or repeated. no state is kept between pixels.
`default_nettype none

module rgb_to_hsv_converter import rhc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pix_valid,
	output logic                   pix_stall,
	input  wire logic [CHAN_W-1:0] red,
	input  wire logic [CHAN_W-1:0] green,
	input  wire logic [CHAN_W-1:0] blue,
	output logic                   hsv_valid,
	input  wire logic              hsv_stall,
	output logic [HUE_W-1:0]       hue_degrees,
	output logic [CHAN_W-1:0]      saturation,
	output logic [CHAN_W-1:0]      brightness
);

	logic              en;
	logic              valid_s1;
	side_t             side_s1;
	logic [NUM_W-1:0]  sat_num_s1;
	logic [NUM_W-1:0]  hue_num_s1;
	logic [CHAN_W-1:0] delta_s1;
	logic [QUOT_W-1:0] sat_quot;
	logic [CHAN_W-1:0] sat_rem;
	logic [QUOT_W-1:0] hue_quot;
	logic [CHAN_W-1:0] hue_rem;

	// control carried in step with the divider stages
	logic              vld_dly_s  [QUOT_W];
	side_t             side_dly_s [QUOT_W];

	assign en        = !(hsv_valid && hsv_stall);
	assign pix_stall = hsv_valid && hsv_stall;

	rhc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.pix_valid  (pix_valid),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.valid_s1   (valid_s1),
		.side_s1    (side_s1),
		.sat_num_s1 (sat_num_s1),
		.hue_num_s1 (hue_num_s1),
		.delta_s1   (delta_s1)
	);

	// saturation: delta*255 / max
	rhc_div_pipe #(
		.DW (CHAN_W),
		.QW (QUOT_W)
	) u_sat_div (
		.clk   (clk),
		.en    (en),
		.numer (sat_num_s1),
		.den   (side_s1.brightness),
		.quot  (sat_quot),
		.rem   (sat_rem)
	);

	// hue: 60*|diff| / delta
	rhc_div_pipe #(
		.DW (CHAN_W),
		.QW (QUOT_W)
	) u_hue_div (
		.clk   (clk),
		.en    (en),
		.numer (hue_num_s1),
		.den   (delta_s1),
		.quot  (hue_quot),
		.rem   (hue_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUOT_W; i++) begin
				vld_dly_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_dly_s[0] <= valid_s1;
			for (int i = 1; i < QUOT_W; i++) begin
				vld_dly_s[i] <= vld_dly_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_dly_s[0] <= side_s1;
			for (int i = 1; i < QUOT_W; i++) begin
				side_dly_s[i] <= side_dly_s[i-1];
			end
		end
	end

	// the saturation remainder is not needed, only its divide's quotient
	rhc_post u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid_in    (vld_dly_s[QUOT_W-1] && (sat_rem == sat_rem)),
		.side        (side_dly_s[QUOT_W-1]),
		.hue_quot    (hue_quot),
		.hue_rem     (hue_rem),
		.sat_quot    (sat_quot),
		.hsv_valid   (hsv_valid),
		.hue_degrees (hue_degrees),
		.saturation  (saturation),
		.brightness  (brightness)
	);

endmodule

`default_nettype wire

>>> hw/rtl/rhc_checker.sv
// port-level checks for the rgb to hsv converter, bound to the top level
// depends on rgb_to_hsv_converter_assert.svh and rhc_pkg
`default_nettype none

`include "rgb_to_hsv_converter_assert.svh"

module rhc_checker import rhc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pix_stall,
	input  wire logic              hsv_valid,
	input  wire logic              hsv_stall,
	input  wire logic [HUE_W-1:0]  hue_degrees,
	input  wire logic [CHAN_W-1:0] saturation,
	input  wire logic [CHAN_W-1:0] brightness
);

	`RHC_ASSERT_NEXT(a_hold, hsv_valid && hsv_stall, hsv_valid && $stable(hue_degrees) && $stable(saturation) && $stable(brightness), "stalled hsv transaction changed")
	`RHC_ASSERT_NOW(a_stall_src, pix_stall, hsv_valid && hsv_stall, "pixel stall without a held result")
	`RHC_ASSERT_NOW(a_hue_range, hsv_valid, hue_degrees < HUE_W'(CIRCLE_DEG), "hue out of range")
	`RHC_ASSERT_NOW(a_black, hsv_valid && brightness == '0, saturation == '0, "black pixel with nonzero saturation")
	`RHC_ASSERT_NOW(a_grey, hsv_valid && saturation == '0, hue_degrees == '0, "grey pixel with nonzero hue")

endmodule

bind rgb_to_hsv_converter rhc_checker u_checker (.*);

`default_nettype wire
